// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also watches reset itself
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sht_pkg.sv =====
`default_nettype none

package sht_pkg;

    localparam int SLOTS     = 1024;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int DEPTH_W   = SLOT_W + 1;
    localparam int CNT_W     = 16;
    localparam int HANDLE_W  = 48;
    localparam int GEN_W     = 32;
    localparam int GEN_SHIFT = 16;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int OSLOT_W   = 10;
    localparam int FREE_W    = 10;

    localparam int S_FIELDS_W = CMD_W + HANDLE_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + HANDLE_W + OSLOT_W + 1 + FREE_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int ENTRY_W    = 1 + CNT_W + HANDLE_W;

    localparam logic [CMD_W-1:0] CMD_OPEN    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DROP    = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_STALE  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NEG    = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_EXEC
    } ctl_state_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic pop_issue;
        logic exec;
        logic clear_wr;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic open_pop;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic                alive;
        logic [CNT_W-1:0]    count;
        logic [HANDLE_W-1:0] handle;
    } slot_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sht_ram.sv =====
`default_nettype none

module sht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sht_ctrl.sv =====
`default_nettype none

module sht_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  sht_pkg::dp_status_t dp_status,
    output sht_pkg::ctl_cmd_t   dp_cmd
);

    import sht_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (dp_status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = dp_status.open_pop ? ST_POP : ST_EXEC;
                end
            end
            ST_POP: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (dp_status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        dp_cmd = '0;
        case (state_reg)
            ST_CLEAR: begin
                dp_cmd.clear_wr = 1'b1;
            end
            ST_IDLE: begin
                dp_cmd.ready  = 1'b1;
                dp_cmd.accept = s_tvalid;
            end
            ST_POP: begin
                dp_cmd.pop_issue = 1'b1;
            end
            ST_EXEC: begin
                dp_cmd.exec = dp_status.out_free;
            end
            default: begin
                dp_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sht_datapath.sv =====
`default_nettype none

module sht_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sht_pkg::ctl_cmd_t             dp_cmd,
    output sht_pkg::dp_status_t           dp_status,
    input  logic [sht_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sht_pkg::M_DATA_W-1:0]  m_tdata
);

    import sht_pkg::*;

    logic [CMD_W-1:0]    in_cmd;
    logic [HANDLE_W-1:0] in_handle;

    logic [CMD_W-1:0]    cmd_reg,    cmd_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [SLOT_W-1:0]   slot_reg,   slot_next;
    logic [DEPTH_W-1:0]  depth_reg,  depth_next;
    logic [GEN_W-1:0]    gen_reg,    gen_next;
    logic [SLOT_W-1:0]   clr_reg,    clr_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg,  m_tdata_next;

    logic                slot_we;
    logic [SLOT_W-1:0]   slot_wr_addr;
    logic [ENTRY_W-1:0]  slot_wr_data;
    logic                slot_re;
    logic [SLOT_W-1:0]   slot_rd_addr;
    logic [ENTRY_W-1:0]  slot_rd_data;

    logic                stk_we;
    logic [SLOT_W-1:0]   stk_wr_addr;
    logic [SLOT_W-1:0]   stk_wr_data;
    logic                stk_re;
    logic [SLOT_W-1:0]   stk_rd_addr;
    logic [SLOT_W-1:0]   stk_rd_data;

    slot_entry_t         rd_entry;
    slot_entry_t         wr_entry;
    logic                stack_nonempty;
    logic                in_range;
    logic                open_ok;
    logic                acq_ok;
    logic                drop_ok;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    cnt_dec;
    logic                drop_zero;
    logic                release_hit;
    logic                push_en;
    logic [HANDLE_W-1:0] new_handle;

    logic [STATUS_W-1:0] res_status;
    logic [HANDLE_W-1:0] res_handle;
    logic [OSLOT_W-1:0]  res_slot;
    logic                res_released;
    logic [DEPTH_W-1:0]  res_depth;

    assign in_cmd    = s_tdata[CMD_W-1:0];
    assign in_handle = s_tdata[CMD_W +: HANDLE_W];

    assign rd_entry       = slot_rd_data;
    assign stack_nonempty = (depth_reg != '0);
    assign in_range       = ({1'b0, handle_reg[GEN_SHIFT-1:0]} < (GEN_SHIFT + 1)'(SLOTS));
    assign open_ok        = (cmd_reg == CMD_OPEN) && stack_nonempty;
    assign acq_ok         = (cmd_reg == CMD_ACQUIRE) && in_range;
    assign drop_ok        = (cmd_reg == CMD_DROP) && in_range;
    assign cnt_inc        = rd_entry.count + 1'b1;
    assign cnt_dec        = rd_entry.count - 1'b1;
    assign drop_zero      = (cnt_dec == '0);
    assign release_hit    = drop_ok && drop_zero && rd_entry.alive;
    assign push_en        = release_hit && (depth_reg < DEPTH_W'(SLOTS));
    assign new_handle     = HANDLE_W'({gen_reg, GEN_SHIFT'(slot_reg)});

    // record written back by the final step
    always_comb begin
        wr_entry = rd_entry;
        case (cmd_reg)
            CMD_OPEN: begin
                wr_entry.alive  = 1'b1;
                wr_entry.count  = cnt_inc;
                wr_entry.handle = new_handle;
            end
            CMD_ACQUIRE: begin
                wr_entry.count = cnt_inc;
            end
            default: begin
                wr_entry.alive = rd_entry.alive & ~drop_zero;
                wr_entry.count = cnt_dec;
            end
        endcase
    end

    // result fields
    always_comb begin
        res_status   = STAT_STALE;
        res_handle   = '0;
        res_slot     = '0;
        res_released = 1'b0;
        res_depth    = depth_reg;
        case (cmd_reg)
            CMD_OPEN: begin
                if (open_ok) begin
                    res_status = STAT_OK;
                    res_handle = new_handle;
                    res_slot   = OSLOT_W'(slot_reg);
                    res_depth  = depth_reg - 1'b1;
                end else begin
                    res_status = STAT_NOFREE;
                end
            end
            CMD_ACQUIRE: begin
                if (acq_ok) begin
                    res_slot   = OSLOT_W'(slot_reg);
                    res_status = (rd_entry.alive && (rd_entry.handle == handle_reg))
                                 ? STAT_OK : STAT_STALE;
                end
            end
            CMD_DROP: begin
                if (drop_ok) begin
                    res_slot     = OSLOT_W'(slot_reg);
                    res_released = release_hit;
                    res_status   = (!drop_zero && cnt_dec[CNT_W-1]) ? STAT_NEG : STAT_OK;
                    res_depth    = depth_reg + DEPTH_W'(push_en);
                end
            end
            default: begin
                res_status = STAT_STALE;
            end
        endcase
    end

    // memory ports
    always_comb begin
        slot_we      = dp_cmd.clear_wr | (dp_cmd.exec & (open_ok | acq_ok | drop_ok));
        slot_wr_addr = dp_cmd.clear_wr ? clr_reg : slot_reg;
        slot_wr_data = dp_cmd.clear_wr ? '0 : wr_entry;
        slot_re      = dp_cmd.pop_issue |
                       (dp_cmd.accept & ((in_cmd == CMD_ACQUIRE) | (in_cmd == CMD_DROP)));
        slot_rd_addr = dp_cmd.pop_issue ? stk_rd_data : in_handle[SLOT_W-1:0];

        stk_we       = dp_cmd.clear_wr | (dp_cmd.exec & push_en);
        stk_wr_addr  = dp_cmd.clear_wr ? clr_reg : depth_reg[SLOT_W-1:0];
        stk_wr_data  = dp_cmd.clear_wr ? (clr_reg + 1'b1) : slot_reg;
        stk_re       = dp_cmd.accept & (in_cmd == CMD_OPEN) & stack_nonempty;
        stk_rd_addr  = SLOT_W'(depth_reg - 1'b1);
    end

    always_comb begin
        cmd_next      = cmd_reg;
        handle_next   = handle_reg;
        slot_next     = slot_reg;
        depth_next    = depth_reg;
        gen_next      = gen_reg;
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (dp_cmd.clear_wr) begin
            clr_next = clr_reg + 1'b1;
        end
        if (dp_cmd.accept) begin
            cmd_next    = in_cmd;
            handle_next = in_handle;
            slot_next   = in_handle[SLOT_W-1:0];
        end
        if (dp_cmd.pop_issue) begin
            slot_next = stk_rd_data;
        end
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (dp_cmd.exec) begin
            depth_next    = res_depth;
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_DATA_W'({FREE_W'(res_depth), res_released, res_slot,
                                       res_handle, res_status});
            if (open_ok) begin
                gen_next = gen_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg    <= DEPTH_W'(SLOTS - 1);
            gen_reg      <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            depth_reg    <= depth_next;
            gen_reg      <= gen_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        handle_reg  <= handle_next;
        slot_reg    <= slot_next;
        m_tdata_reg <= m_tdata_next;
    end

    sht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_we),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (slot_re),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    sht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_re),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    assign dp_status.clear_done = (clr_reg == SLOT_W'(SLOTS - 1));
    assign dp_status.open_pop   = (in_cmd == CMD_OPEN) && stack_nonempty;
    assign dp_status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/session_handle_table_core.sv =====
// channel  dir  tdata fields (lsb first)
// s_       in   command[1:0] handle[49:2], zero pad to 56 bits
// m_       out  status[1:0] new_handle[49:2] slot[59:50] released[60] free_slots[70:61]
//
// acquire, drop and rejected commands go from idle to exec, open goes through pop first
// (stack read then slot read); each item reads and writes the slot memory at most once
// after reset a clearing pass fills both memories, s_tready stays low
// the result sits in an output register; the next item is accepted while it waits
// if that register is still full, the final step holds until m_tready
`default_nettype none

module session_handle_table_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sht_pkg::S_DATA_W-1:0]  s_tdata,   // command, handle
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sht_pkg::M_DATA_W-1:0]  m_tdata    // status, new_handle, slot, released, free_slots
);

    import sht_pkg::*;

    ctl_cmd_t   dp_cmd;
    dp_status_t dp_status;

    sht_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    sht_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    assign s_tready = dp_cmd.ready;

endmodule

`default_nettype wire

// ===== hw/rtl/sht_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module sht_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sht_pkg::M_DATA_W-1:0]  m_tdata
);

    import sht_pkg::*;

    `ASSERT_NXT_ALWAYS(a_clear_after_reset, aclk, !aresetn, !s_tready, "ready during clearing pass")

    `ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken while busy")

    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    `ASSERT_IMP(a_handle_only_ok, aclk, aresetn, m_tvalid && (m_tdata[1:0] != STAT_OK), m_tdata[49:2] == '0, "handle on failed item")

endmodule

bind session_handle_table_core sht_checker u_sht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
